### rtl/core/cgi_pkg.sv
`timescale 1ns / 1ps
// Package for the colour gradient interpolator: sizes, codes, payload and command types.
// It also holds the channel blend function. It depends on nothing else.
package cgi_pkg;

    localparam int MAX_STOPS   = 16;
    localparam int STOP_ADDR_W = $clog2(MAX_STOPS);
    localparam int COUNT_W     = 5;
    localparam int POS_W       = 17;
    localparam int FRAC_W      = 16;
    localparam int RGBA_W      = 32;
    localparam int CH_W        = 8;
    localparam int LOC_W       = FRAC_W + STOP_ADDR_W;
    localparam int ACC_W       = CH_W + FRAC_W + 1;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT   = REG_IDX_W'(0);
    localparam logic [COUNT_W-1:0]   STOP_COUNT_RESET = COUNT_W'(2);
    localparam logic [COUNT_W-1:0]   STOP_COUNT_MIN   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0]   STOP_COUNT_MAX   = COUNT_W'(MAX_STOPS);
    localparam logic [FRAC_W:0]      ONE_Q16          = (FRAC_W + 1)'(1) << FRAC_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [3:0]        stop_index;
        logic [RGBA_W-1:0] stop_rgba;
        logic [POS_W-1:0]  position;
    } cgi_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } cgi_out_t;

    typedef struct packed {
        logic                   is_write;
        logic [STOP_ADDR_W-1:0] wr_addr;
        logic [RGBA_W-1:0]      rgba;
        logic [STOP_ADDR_W-1:0] rd_addr0;
        logic [STOP_ADDR_W-1:0] rd_addr1;
        logic [FRAC_W-1:0]      frac;
    } cgi_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cgi_q_status_t;

    function automatic logic [CH_W-1:0] blend_channel(
        input logic [CH_W-1:0]   a,
        input logic [CH_W-1:0]   b,
        input logic [FRAC_W-1:0] frac
    );
        logic [FRAC_W:0]  wa;
        logic [ACC_W-1:0] pa;
        logic [ACC_W-1:0] pb;
        logic [ACC_W-1:0] acc;
        wa  = ONE_Q16 - {1'b0, frac};
        pa  = ACC_W'(a) * ACC_W'(wa);
        pb  = ACC_W'(b) * ACC_W'(frac);
        acc = pa + pb;
        return acc[FRAC_W +: CH_W];
    endfunction

endpackage

### rtl/core/color_gradient_interpolator_unit.sv
`timescale 1ns / 1ps
// Top level of the colour gradient interpolator: APB register, front end, queue, back end.
// Depends on cgi_pkg, cgi_front, cgi_queue and cgi_back.
// Throughput: one transaction per cycle while the queue is not full; the stop table and the
// blend stage are pipelined. An evaluate transaction passes through the queue, then the
// registered read of the stop table, then the registered blended result at the output.
// Reset: aresetn clears stop_count to 2 and empties the queue and pipeline; the stop table
// is not cleared and holds undefined data until written.
module color_gradient_interpolator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cgi_pkg::cgi_in_t               s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cgi_pkg::cgi_out_t              m_payload,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cgi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cgi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cgi_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import cgi_pkg::*;

    logic [COUNT_W-1:0]   stop_count_reg, stop_count_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic                 q_push;
    logic                 q_pop;
    cgi_cmd_t             q_cmd_in;
    cgi_cmd_t             q_cmd_out;
    cgi_q_status_t        q_status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        stop_count_next = stop_count_reg;
        if (cfg_write && (reg_idx == REG_STOP_COUNT)) begin
            stop_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg <= STOP_COUNT_RESET;
        end else begin
            stop_count_reg <= stop_count_next;
        end
    end

    always_comb begin
        if (reg_idx == REG_STOP_COUNT) begin
            prdata = APB_DATA_W'(stop_count_reg);
        end else begin
            prdata = '0;
        end
    end

    cgi_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .stop_count (stop_count_reg),
        .q_status   (q_status),
        .push       (q_push),
        .cmd        (q_cmd_in)
    );

    cgi_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .cmd_in  (q_cmd_in),
        .pop     (q_pop),
        .cmd_out (q_cmd_out),
        .status  (q_status)
    );

    cgi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (q_cmd_out),
        .q_status  (q_status),
        .pop       (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("Command pushed into a full queue.");

    a_eval_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.opcode == OP_EVAL)) |=> !q_status.empty)
        else $error("Accepted evaluate transaction did not reach the queue.");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("Command popped from an empty queue.");

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid directly after reset.");

endmodule

### rtl/core/cgi_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
// It depends on nothing else.
module cgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata0_reg <= mem_reg[raddr0];
            rdata1_reg <= mem_reg[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

### rtl/core/cgi_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, sorts stop writes from evaluations and works out
// the segment, the fraction and the stop addresses. Depends on cgi_pkg.
module cgi_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cgi_pkg::cgi_in_t              s_payload,
    input  logic [cgi_pkg::COUNT_W-1:0]   stop_count,
    input  cgi_pkg::cgi_q_status_t        q_status,
    output logic                          push,
    output cgi_pkg::cgi_cmd_t             cmd
);
    import cgi_pkg::*;

    logic [STOP_ADDR_W-1:0] last_idx;
    logic [LOC_W-1:0]       loc;
    logic [STOP_ADDR_W-1:0] seg;
    logic                   saturate;
    logic                   in_range;

    always_comb begin
        if (stop_count < STOP_COUNT_MIN) begin
            last_idx = STOP_ADDR_W'(STOP_COUNT_MIN - COUNT_W'(1));
        end else if (stop_count > STOP_COUNT_MAX) begin
            last_idx = STOP_ADDR_W'(STOP_COUNT_MAX - COUNT_W'(1));
        end else begin
            last_idx = STOP_ADDR_W'(stop_count - COUNT_W'(1));
        end
    end

    assign saturate = s_payload.position[FRAC_W];
    assign loc      = LOC_W'(s_payload.position[FRAC_W-1:0]) * LOC_W'(last_idx);
    assign seg      = loc[FRAC_W +: STOP_ADDR_W];
    assign in_range = 32'(s_payload.stop_index) < MAX_STOPS;

    always_comb begin
        cmd.is_write = (s_payload.opcode == OP_WRITE);
        cmd.wr_addr  = STOP_ADDR_W'(s_payload.stop_index);
        cmd.rgba     = s_payload.stop_rgba;
        if (saturate) begin
            cmd.rd_addr0 = last_idx;
            cmd.rd_addr1 = last_idx;
            cmd.frac     = '0;
        end else begin
            cmd.rd_addr0 = seg;
            cmd.rd_addr1 = seg + STOP_ADDR_W'(1);
            cmd.frac     = loc[FRAC_W-1:0];
        end
    end

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready && ((s_payload.opcode == OP_EVAL) || in_range);

endmodule

### rtl/core/cgi_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on cgi_pkg.
module cgi_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  cgi_pkg::cgi_cmd_t      cmd_in,
    input  logic                   pop,
    output cgi_pkg::cgi_cmd_t      cmd_out,
    output cgi_pkg::cgi_q_status_t status
);
    import cgi_pkg::*;

    cgi_cmd_t           entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_out      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### rtl/core/cgi_back.sv
`timescale 1ns / 1ps
// Back end: carries out queued commands, writing stops to the table or reading two stops
// and blending them into a registered result. Depends on cgi_pkg and cgi_ram.
module cgi_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cgi_pkg::cgi_cmd_t      cmd,
    input  cgi_pkg::cgi_q_status_t q_status,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cgi_pkg::cgi_out_t      m_payload
);
    import cgi_pkg::*;

    logic              a_valid_reg, a_valid_next;
    logic [FRAC_W-1:0] frac_reg;
    logic              m_valid_reg, m_valid_next;
    cgi_out_t          m_payload_reg;
    cgi_out_t          blend;
    logic              out_free;
    logic              pop_eval;
    logic [RGBA_W-1:0] c0;
    logic [RGBA_W-1:0] c1;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = !q_status.empty && (cmd.is_write || !a_valid_reg || out_free);
    assign pop_eval = pop && !cmd.is_write;

    cgi_ram #(
        .WIDTH (RGBA_W),
        .DEPTH (MAX_STOPS)
    ) u_stop_ram (
        .aclk   (aclk),
        .we     (pop && cmd.is_write),
        .waddr  (cmd.wr_addr),
        .wdata  (cmd.rgba),
        .re     (pop_eval),
        .raddr0 (cmd.rd_addr0),
        .raddr1 (cmd.rd_addr1),
        .rdata0 (c0),
        .rdata1 (c1)
    );

    always_comb begin
        blend.red   = blend_channel(c0[3*CH_W +: CH_W], c1[3*CH_W +: CH_W], frac_reg);
        blend.green = blend_channel(c0[2*CH_W +: CH_W], c1[2*CH_W +: CH_W], frac_reg);
        blend.blue  = blend_channel(c0[CH_W +: CH_W], c1[CH_W +: CH_W], frac_reg);
        blend.alpha = blend_channel(c0[0 +: CH_W], c1[0 +: CH_W], frac_reg);
    end

    always_comb begin
        if (pop_eval) begin
            a_valid_next = 1'b1;
        end else if (out_free) begin
            a_valid_next = 1'b0;
        end else begin
            a_valid_next = a_valid_reg;
        end
        if (a_valid_reg && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_eval) begin
            frac_reg <= cmd.frac;
        end
        if (a_valid_reg && out_free) begin
            m_payload_reg <= blend;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

### sim/tb_color_gradient_interpolator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for color_gradient_interpolator_unit: stop writes and gradient
// evaluations across several stop counts and handshake stall patterns.
// Depends on cgi_pkg and the color_gradient_interpolator_unit RTL.
module tb_color_gradient_interpolator_unit;
    import cgi_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 11;
    localparam int RESULT_LATENCY   = 4;
    localparam int STALL_LIMIT      = 20000;
    localparam int RANDOM_PER_PHASE = 40;
    localparam int PHASES           = 10;
    localparam int MAX_REPORTS      = 10;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(65536);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(131071);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    cgi_in_t               s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    cgi_out_t              m_payload;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cgi_in_t            pending_items[$];
    cgi_out_t           expected_colours[$];
    logic [RGBA_W-1:0]  stop_mirror [MAX_STOPS];
    logic [COUNT_W-1:0] count_mirror = STOP_COUNT_RESET;
    logic [COUNT_W-1:0] phase_counts [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17,
                                                  5'd5, 5'd9, 5'd3, 5'd2, 5'd16};
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;

    color_gradient_interpolator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic cgi_out_t gradient_colour(input logic [POS_W-1:0] pos);
        int unsigned       n;
        int unsigned       loc;
        int unsigned       seg;
        int unsigned       frac;
        int unsigned       a;
        int unsigned       b;
        logic [RGBA_W-1:0] c0;
        logic [RGBA_W-1:0] c1;
        logic [RGBA_W-1:0] mix;
        n = 32'(count_mirror);
        if (n < 2) n = 2;
        if (n > MAX_STOPS) n = MAX_STOPS;
        if (pos >= POS_ONE) begin
            c0   = stop_mirror[STOP_ADDR_W'(n - 1)];
            c1   = c0;
            frac = 0;
        end else begin
            loc  = 32'(pos) * (n - 1);
            seg  = loc >> 16;
            frac = loc & 32'hFFFF;
            c0   = stop_mirror[STOP_ADDR_W'(seg)];
            c1   = stop_mirror[STOP_ADDR_W'(seg + 1)];
        end
        for (int ch = 0; ch < 4; ch++) begin
            a = 32'(c0[24 - 8 * ch +: 8]);
            b = 32'(c1[24 - 8 * ch +: 8]);
            mix[24 - 8 * ch +: 8] = 8'((a * (65536 - frac) + b * frac) >> 16);
        end
        return cgi_out_t'(mix);
    endfunction

    task automatic push_write(input logic [3:0] index, input logic [RGBA_W-1:0] rgba);
        cgi_in_t item;
        item            = '0;
        item.opcode     = OP_WRITE;
        item.stop_index = index;
        item.stop_rgba  = rgba;
        item.position   = POS_W'($urandom_range(131071));
        pending_items.push_back(item);
    endtask

    task automatic push_eval(input logic [POS_W-1:0] pos);
        cgi_in_t item;
        item            = '0;
        item.opcode     = OP_EVAL;
        item.stop_index = 4'($urandom_range(15));
        item.stop_rgba  = $urandom;
        item.position   = pos;
        pending_items.push_back(item);
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || s_valid || expected_colours.size() != 0)
            @(posedge aclk);
        repeat (RESULT_LATENCY) @(posedge aclk);
    endtask

    task automatic set_stop_count(input logic [COUNT_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_STOP_COUNT, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        count_mirror  = value;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_payload.opcode == OP_WRITE) begin
                    stop_mirror[s_payload.stop_index] = s_payload.stop_rgba;
                end else begin
                    expected_colours.push_back(gradient_colour(s_payload.position));
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_payload <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        cgi_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_colours.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result transaction: %h", m_payload);
                end else begin
                    want = expected_colours.pop_front();
                    if (m_payload.red !== want.red || m_payload.green !== want.green ||
                        m_payload.blue !== want.blue || m_payload.alpha !== want.alpha) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"colour mismatch: expected r%h g%h b%h a%h, ",
                                      "got r%h g%h b%h a%h"},
                                     want.red, want.green, want.blue, want.alpha,
                                     m_payload.red, m_payload.green, m_payload.blue,
                                     m_payload.alpha);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned pick;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole table first so that no evaluation reads an unwritten stop.
        push_write(4'd0, 32'h0000_0000);
        push_write(4'd1, 32'hFFFF_FFFF);
        for (int k = 2; k < MAX_STOPS; k++) push_write(4'(k), $urandom);
        push_eval(POS_W'(0));
        push_eval(POS_ONE);
        push_eval(POS_W'(32768));
        push_eval(POS_W'(65535));
        push_eval(POS_W'(1));
        push_eval(POS_MAX);
        settle();
        set_stop_count(COUNT_W'(16));
        push_eval(POS_W'(4369));
        push_eval(POS_W'(4370));
        push_eval(POS_W'(65535));
        push_eval(POS_ONE);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            set_stop_count(phase_counts[p]);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                pick = $urandom_range(9);
                if (pick < 3) begin
                    push_write(4'($urandom_range(15)), $urandom);
                end else if (pick == 3) begin
                    push_eval(POS_W'(0));
                end else if (pick == 4) begin
                    push_eval(POS_ONE);
                end else if (pick == 5) begin
                    push_eval(POS_W'($urandom_range(131071, 65537)));
                end else begin
                    push_eval(POS_W'($urandom_range(65535)));
                end
            end
            settle();
        end

        if (mismatch_count == 0 && expected_colours.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/cgi_pkg.sv
rtl/core/cgi_ram.sv
rtl/core/cgi_front.sv
rtl/core/cgi_queue.sv
rtl/core/cgi_back.sv
rtl/core/color_gradient_interpolator_unit.sv
sim/tb_color_gradient_interpolator_unit.sv
